// ===== src/mcsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcsa_pkg;

  localparam int ChanW       = 3;
  localparam int SmpW        = 12;
  localparam int SumW        = 24;
  localparam int CntW        = 8;
  localparam int OutW        = 31;
  localparam int NumChannels = 8;
  localparam int ScaleShift  = 4;
  localparam int OutShift    = 15;
  localparam int QuotW       = OutW - OutShift;
  localparam int DivSteps    = SumW;
  localparam int StepW       = $clog2(DivSteps);

  localparam logic [CntW-1:0] LenReset = 8'd200;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StAccum  = 4'b0010,
    StDivide = 4'b0100,
    StDone   = 4'b1000
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic accum;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic dump;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/mcsa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcsa_ctrl
  import mcsa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t dp_status_i,
  output dp_cmd_t         dp_cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    dp_cmd_o    = '0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          dp_cmd_o.latch_in = 1'b1;
          state_d           = StAccum;
        end
      end
      StAccum: begin
        dp_cmd_o.accum = 1'b1;
        state_d        = dp_status_i.dump ? StDivide : StIdle;
      end
      StDivide: begin
        dp_cmd_o.div_step = 1'b1;
        if (dp_status_i.div_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // hold the quotient until the output slot is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          dp_cmd_o.load_out = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/mcsa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcsa_dp
  import mcsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ChanW-1:0] channel_i,
  input  wire logic [SmpW-1:0]  sample_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CntW-1:0]  cfg_wdata_i,
  input  wire dp_cmd_t          dp_cmd_i,
  output dp_status_t            dp_status_o,
  output logic [ChanW-1:0]      out_channel_o,
  output logic [OutW-1:0]       average_value_o
);

  logic [CntW-1:0]  len_q;
  logic [SumW-1:0]  sums_q   [NumChannels];
  logic [CntW-1:0]  counts_q [NumChannels];
  logic [StepW-1:0] step_q;

  logic [ChanW-1:0] ch_q;
  logic [SmpW-1:0]  smp_q;
  logic [CntW-1:0]  rem_q;
  logic [SumW-1:0]  quo_q;
  logic [CntW-1:0]  dvs_q;
  logic [ChanW-1:0] out_ch_q;
  logic [OutW-1:0]  avg_q;

  logic [SumW-1:0]  smp_scaled;
  logic [SumW-1:0]  sum_new;
  logic [CntW-1:0]  cnt_new;
  logic             dump;
  logic [CntW:0]    shifted;
  logic             ge;
  logic [CntW-1:0]  rem_next;

  assign smp_scaled = SumW'({smp_q, {ScaleShift{1'b0}}});
  assign sum_new    = sums_q[ch_q] + smp_scaled;
  assign cnt_new    = counts_q[ch_q] + CntW'(1);
  // a wrapped count never dumps
  assign dump       = (cnt_new != '0) && (cnt_new >= len_q);

  // restoring divider, one quotient bit per cycle
  assign shifted  = {rem_q, quo_q[SumW-1]};
  assign ge       = (shifted >= {1'b0, dvs_q});
  assign rem_next = ge ? CntW'(shifted - {1'b0, dvs_q}) : shifted[CntW-1:0];

  assign dp_status_o.dump     = dump;
  assign dp_status_o.div_last = (step_q == StepW'(DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenReset;
      step_q <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        sums_q[i]   <= '0;
        counts_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (dp_cmd_i.accum) begin
        step_q <= '0;
        if (dump) begin
          sums_q[ch_q]   <= '0;
          counts_q[ch_q] <= '0;
        end else begin
          sums_q[ch_q]   <= sum_new;
          counts_q[ch_q] <= cnt_new;
        end
      end else if (dp_cmd_i.div_step) begin
        step_q <= step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.latch_in) begin
      ch_q  <= channel_i;
      smp_q <= sample_i;
    end
    if (dp_cmd_i.accum) begin
      quo_q <= sum_new;
      rem_q <= '0;
      dvs_q <= cnt_new;
    end else if (dp_cmd_i.div_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[SumW-2:0], ge};
    end
    if (dp_cmd_i.load_out) begin
      out_ch_q <= ch_q;
      avg_q    <= {quo_q[QuotW-1:0], {OutShift{1'b0}}};
    end
  end

  assign out_channel_o   = out_ch_q;
  assign average_value_o = avg_q;

endmodule

`default_nettype wire

// ===== src/multichannel_sample_averager_unit.sv =====
// A sample that does not complete its block passes through accept and accumulate only.
// A sample that completes a block goes from accept to a valid result through accumulate,
// the bit-serial restoring divider over the 24-bit sum, and load; the divider is shared.
// Intake stays closed until the last sample is through these steps. A result held in the
// output register does not block intake, but a further one waiting to be loaded does.
// Reset: asynchronous active low; clears sums, counts and valids, length returns to 200.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_sample_averager_unit
  import mcsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ChanW-1:0] channel_i,
  input  wire logic [SmpW-1:0]  sample_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ChanW-1:0]      out_channel_o,
  output logic [OutW-1:0]       average_value_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CntW-1:0]  cfg_wdata_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mcsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  mcsa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_i       (channel_i),
    .sample_i        (sample_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .dp_cmd_i        (dp_cmd),
    .dp_status_o     (dp_status),
    .out_channel_o   (out_channel_o),
    .average_value_o (average_value_o)
  );

  // an accepted transaction keeps intake closed for its accumulate cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("intake open right after an accepted transaction");

  // a new result is only loaded while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in flight");

  // the divider never iterates while intake is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.div_step |-> in_stall_o)
    else $error("divider stepping while idle");

endmodule

`default_nettype wire

// ===== dv/multichannel_sample_averager_unit_tb.sv =====
`timescale 1ns / 1ps

module multichannel_sample_averager_unit_tb
  import mcsa_pkg::*;
();

  localparam int ClkPeriod     = 10;
  localparam int SettleCycles  = 40;
  localparam int WatchdogLimit = 3000;
  localparam int TargetSamples = 850;
  localparam int MaxReports    = 10;

  typedef struct {
    logic [ChanW-1:0] chan;
    logic [SmpW-1:0]  smp;
  } sample_txn_t;

  typedef struct {
    logic [ChanW-1:0] chan;
    logic [OutW-1:0]  value;
  } avg_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ChanW-1:0] channel_i = '0;
  logic [SmpW-1:0]  sample_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ChanW-1:0] out_channel_o;
  logic [OutW-1:0]  average_value_o;
  logic             cfg_we_i = 1'b0;
  logic [CntW-1:0]  cfg_wdata_i = '0;

  multichannel_sample_averager_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_channel_o  (out_channel_o),
    .average_value_o(average_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  sample_txn_t     sample_pending_q[$];
  avg_result_t     avg_expect_q[$];

  // Shadow of the block's per-channel accumulators and length register
  logic [SumW-1:0] shadow_sum[NumChannels];
  logic [CntW-1:0] shadow_cnt[NumChannels];
  logic [CntW-1:0] shadow_len = LenReset;

  int mismatch_cnt = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int stall_mode   = 0;
  int stall_run    = 0;

  initial begin
    for (int c = 0; c < NumChannels; c++) begin
      shadow_sum[c] = '0;
      shadow_cnt[c] = '0;
    end
  end

  function automatic void predict_average(input logic [ChanW-1:0] ch,
                                          input logic [SmpW-1:0] smp);
    logic [SumW-1:0] sum_n;
    logic [CntW-1:0] cnt_n;
    logic [31:0]     quot;
    avg_result_t     res;
    if (int'(ch) >= NumChannels) return;
    sum_n = shadow_sum[ch] + (SumW'(smp) << ScaleShift);
    cnt_n = shadow_cnt[ch] + CntW'(1);
    if (cnt_n != '0 && cnt_n >= shadow_len) begin
      quot = 32'(sum_n) / 32'(cnt_n);
      res.chan  = ch;
      res.value = OutW'(quot << OutShift);
      avg_expect_q.push_back(res);
      shadow_sum[ch] = '0;
      shadow_cnt[ch] = '0;
    end else begin
      shadow_sum[ch] = sum_n;
      shadow_cnt[ch] = cnt_n;
    end
  endfunction

  function automatic logic [SmpW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return '1;
      default: return SmpW'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic queue_sample(input logic [ChanW-1:0] ch, input logic [SmpW-1:0] smp);
    sample_txn_t txn;
    txn.chan = ch;
    txn.smp  = smp;
    sample_pending_q.push_back(txn);
  endtask

  task automatic write_length(input logic [CntW-1:0] len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hold off until every queued sample is sent and every average has come back
  task automatic drain_and_settle();
    @(negedge clk_i);
    while (sample_pending_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (avg_expect_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (sample_pending_q.size() != 0) begin
        sample_txn_t txn;
        txn = sample_pending_q.pop_front();
        in_valid_i <= 1'b1;
        channel_i  <= txn.chan;
        sample_i   <= txn.smp;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: never stalling, stalling at random, or mostly stalling, switched at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_run  = $urandom_range(20, 80);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: predict on accepted samples, check accepted averages, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (cfg_we_i) begin
        shadow_len = cfg_wdata_i;
        idle_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        avg_result_t exp_res;
        idle_cycles = 0;
        if (avg_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("%0t: unexpected average transaction: channel %0d value 0x%08h",
                     $time, out_channel_o, average_value_o);
        end else begin
          exp_res = avg_expect_q.pop_front();
          if (out_channel_o !== exp_res.chan || average_value_o !== exp_res.value) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports)
              $display("%0t: average mismatch: expected ch %0d val 0x%08h, got ch %0d val 0x%08h",
                       $time, exp_res.chan, exp_res.value, out_channel_o, average_value_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        predict_average(channel_i, sample_i);
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d averages outstanding",
                 $time, avg_expect_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int               n_queued;
    int               n_phase;
    logic [CntW-1:0]  len_pick;
    logic [ChanW-1:0] ch_pick;
    logic [ChanW-1:0] ch_now;
    bit               narrow;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset length: one full block of 200 samples on one channel
    ch_pick = 3'($urandom_range(0, 7));
    for (int i = 0; i < int'(LenReset); i++) queue_sample(ch_pick, rand_sample());
    n_queued = int'(LenReset);
    drain_and_settle();

    // Length one: every channel, sample extremes and alternating bit patterns
    write_length(8'd1);
    for (int c = 0; c < NumChannels; c++)
      queue_sample(ChanW'(c), (c % 2) ? 12'h000 : 12'hfff);
    queue_sample(3'd2, 12'haaa);
    queue_sample(3'd5, 12'h555);
    drain_and_settle();

    // Zero length: each sample is dumped on its own
    write_length(8'd0);
    queue_sample(3'd7, 12'hfff);
    queue_sample(3'd0, 12'h001);
    queue_sample(3'd4, 12'h800);
    drain_and_settle();

    // Partial blocks, then lower the length under the running counts
    write_length(8'd8);
    queue_sample(3'd3, 12'h001);
    queue_sample(3'd3, 12'hfff);
    queue_sample(3'd3, 12'h7ff);
    queue_sample(3'd3, 12'h800);
    queue_sample(3'd3, 12'h123);
    queue_sample(3'd6, 12'hfff);
    drain_and_settle();
    write_length(8'd2);
    queue_sample(3'd3, 12'h456);
    queue_sample(3'd6, 12'h000);
    n_queued += 21;
    drain_and_settle();

    // Maximum length with mostly full-scale samples drives the sum to its top
    write_length(8'd255);
    ch_pick = 3'($urandom_range(0, 7));
    for (int i = 0; i < 255; i++)
      queue_sample(ch_pick, ($urandom_range(0, 7) != 0) ? 12'hfff : rand_sample());
    n_queued += 255;
    drain_and_settle();

    while (n_queued < TargetSamples) begin
      case ($urandom_range(0, 7))
        0:       len_pick = 8'd0;
        1:       len_pick = 8'd1;
        default: len_pick = 8'($urandom_range(2, 16));
      endcase
      write_length(len_pick);
      n_phase = $urandom_range(20, 60);
      narrow  = 1'($urandom_range(0, 1));
      ch_pick = 3'($urandom_range(0, 7));
      for (int i = 0; i < n_phase; i++) begin
        ch_now = narrow ? ch_pick + 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        queue_sample(ch_now, rand_sample());
      end
      n_queued += n_phase;
      drain_and_settle();
    end

    if (mismatch_cnt == 0 && avg_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mcsa_pkg.sv
src/mcsa_ctrl.sv
src/mcsa_dp.sv
src/multichannel_sample_averager_unit.sv
dv/multichannel_sample_averager_unit_tb.sv
